[hdl/lfs_pkg.sv]
// Shared types and constants for the line follow steering unit.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package lfs_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int IDX_W     = $clog2(MAX_WIDTH);
   localparam int WID_W     = 11;
   localparam int PIX_W     = 8;
   localparam int SPD_W     = 9;
   localparam int CSR_IDX_W = 3;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

   typedef enum logic [1:0] {
      DIR_NONE     = 2'd0,
      DIR_LEFT     = 2'd1,
      DIR_RIGHT    = 2'd2,
      DIR_CENTERED = 2'd3
   } dir_type;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WHITE_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_BAND     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_SPEED       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_SPEED       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LOST_LIMIT      = 3'd5;

   localparam logic [WID_W-1:0] RST_FRAME_WIDTH     = 11'd200;
   localparam logic [PIX_W-1:0] RST_WHITE_THRESHOLD = 8'd255;
   localparam logic [7:0]       RST_CENTER_BAND     = 8'd5;
   localparam logic [7:0]       RST_MIN_SPEED       = 8'd10;
   localparam logic [7:0]       RST_MAX_SPEED       = 8'd20;
   localparam logic [7:0]       RST_LOST_LIMIT      = 8'd7;
   localparam logic signed [SPD_W-1:0] RST_HOLD     = 9'sd10;
   localparam logic [7:0]       LOST_MAX            = 8'd255;

   typedef struct packed {
      logic [WID_W-1:0] frame_width;
      logic [PIX_W-1:0] white_threshold;
      logic [7:0]       center_band;
      logic [7:0]       min_speed;
      logic [7:0]       max_speed;
      logic [7:0]       lost_limit;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

[hdl/lfs_front.sv]
// Front end: takes pixel words, tracks the first white run and classifies the row.
// Pushes one direction per row into the queue. Depends on lfs_pkg.
`timescale 1ns / 1ps

module lfs_front import lfs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             pixel_accept,
   input  logic [PIX_W-1:0] pixel_value,
   output logic             push,
   output dir_type          push_dir
);

   logic [IDX_W-1:0] pixel_index_ff, pixel_index_in;
   logic [IDX_W-1:0] run_start_ff, run_start_in;
   logic             run_open_ff, run_open_in;
   logic             row_decided_ff, row_decided_in;
   dir_type          row_dir_ff, row_dir_in;

   logic [WID_W-1:0] eff_w;
   logic             last;
   logic             white;
   logic [IDX_W-1:0] run_end;
   logic [WID_W:0]   sum_s;
   logic [WID_W:0]   band2;
   logic [WID_W:0]   w_ext;
   dir_type          cls;

   always_comb begin
      if (cfg.frame_width < WID_W'(2)) begin
         eff_w = WID_W'(2);
      end else if (cfg.frame_width > WID_W'(MAX_WIDTH)) begin
         eff_w = WID_W'(MAX_WIDTH);
      end else begin
         eff_w = cfg.frame_width;
      end
   end

   assign last    = {1'b0, pixel_index_ff} >= (eff_w - WID_W'(1));
   assign white   = (pixel_value >= cfg.white_threshold) && !last;
   assign run_end = (pixel_index_ff != '0) ? pixel_index_ff - IDX_W'(1) : '0;
   assign sum_s   = (WID_W+1)'(run_start_ff) + (WID_W+1)'(run_end);
   assign band2   = (WID_W+1)'({cfg.center_band, 1'b0});
   assign w_ext   = (WID_W+1)'(eff_w);

   always_comb begin
      if ((sum_s + band2 > w_ext) && (sum_s < w_ext + band2)) begin
         cls = DIR_CENTERED;
      end else if (sum_s < w_ext) begin
         cls = DIR_LEFT;
      end else begin
         cls = DIR_RIGHT;
      end
   end

   always_comb begin
      pixel_index_in = pixel_index_ff;
      run_start_in   = run_start_ff;
      run_open_in    = run_open_ff;
      row_decided_in = row_decided_ff;
      row_dir_in     = row_dir_ff;
      if (pixel_accept) begin
         if (!row_decided_ff) begin
            if (white) begin
               if (!run_open_ff) begin
                  run_open_in  = 1'b1;
                  run_start_in = pixel_index_ff;
               end
            end else if (run_open_ff) begin
               row_dir_in     = cls;
               row_decided_in = 1'b1;
            end
         end
         if (last) begin
            pixel_index_in = '0;
            run_start_in   = '0;
            run_open_in    = 1'b0;
            row_decided_in = 1'b0;
            row_dir_in     = DIR_NONE;
         end else begin
            pixel_index_in = pixel_index_ff + IDX_W'(1);
         end
      end
   end

   // the last pixel is never white, so an open run closes on it
   assign push     = pixel_accept && last;
   assign push_dir = row_decided_ff ? row_dir_ff : (run_open_ff ? cls : DIR_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_index_ff <= '0;
         run_start_ff   <= '0;
         run_open_ff    <= 1'b0;
         row_decided_ff <= 1'b0;
         row_dir_ff     <= DIR_NONE;
      end else begin
         pixel_index_ff <= pixel_index_in;
         run_start_ff   <= run_start_in;
         run_open_ff    <= run_open_in;
         row_decided_ff <= row_decided_in;
         row_dir_ff     <= row_dir_in;
      end
   end

endmodule

[hdl/lfs_fifo.sv]
// Short queue of row directions between the front end and the back end.
// Depends on lfs_pkg.
`timescale 1ns / 1ps

module lfs_fifo import lfs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  dir_type         push_dir,
   input  logic            pop,
   output dir_type         pop_dir,
   output fifo_status_type status
);

   dir_type                 entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_PTR_W:0]     count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   assign status.full  = count_ff == (FIFO_PTR_W+1)'(FIFO_DEPTH);
   assign status.empty = count_ff == '0;
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_dir      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (FIFO_PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (FIFO_PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_dir;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hdl/lfs_back.sv]
// Back end: turns each row direction into wheel speeds, tracks lost rows,
// and holds the result word until taken. Depends on lfs_pkg.
`timescale 1ns / 1ps

module lfs_back import lfs_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  fifo_status_type         status,
   input  dir_type                 pop_dir,
   output logic                    pop,
   output logic                    out_valid,
   input  logic                    out_ready,
   output dir_type                 out_dir,
   output logic signed [SPD_W-1:0] out_left,
   output logic signed [SPD_W-1:0] out_right
);

   logic [7:0]              lost_ff, lost_in;
   logic signed [SPD_W-1:0] left_hold_ff, left_hold_in;
   logic signed [SPD_W-1:0] right_hold_ff, right_hold_in;
   logic                    valid_ff, valid_in;
   dir_type                 dir_ff;
   logic signed [SPD_W-1:0] left_ff, right_ff;
   logic signed [SPD_W-1:0] mn;
   logic signed [SPD_W-1:0] mx;

   assign mn  = $signed({1'b0, cfg.min_speed});
   assign mx  = $signed({1'b0, cfg.max_speed});
   assign pop = !status.empty && (!valid_ff || out_ready);

   always_comb begin
      lost_in       = lost_ff;
      left_hold_in  = left_hold_ff;
      right_hold_in = right_hold_ff;
      case (pop_dir)
         DIR_LEFT: begin
            lost_in       = '0;
            left_hold_in  = mn;
            right_hold_in = mx;
         end
         DIR_RIGHT: begin
            lost_in       = '0;
            left_hold_in  = mx;
            right_hold_in = mn;
         end
         DIR_CENTERED: begin
            lost_in       = '0;
            left_hold_in  = mx;
            right_hold_in = mx;
         end
         default: begin
            if (lost_ff != LOST_MAX) begin
               lost_in = lost_ff + 8'd1;
            end
            if (lost_in > cfg.lost_limit) begin
               left_hold_in  = -mx;
               right_hold_in = mx;
            end
         end
      endcase
      valid_in = pop ? 1'b1 : (valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lost_ff       <= '0;
         left_hold_ff  <= RST_HOLD;
         right_hold_ff <= RST_HOLD;
         valid_ff      <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            lost_ff       <= lost_in;
            left_hold_ff  <= left_hold_in;
            right_hold_ff <= right_hold_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         dir_ff   <= pop_dir;
         left_ff  <= left_hold_in;
         right_ff <= right_hold_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_dir   = dir_ff;
   assign out_left  = left_ff;
   assign out_right = right_ff;

endmodule

[hdl/line_follow_steering_unit.sv]
// Line follow steering unit: one pixel word per cycle in, one steering word per row out.
// Throughput: one pixel per cycle; stalls only when the four-entry row queue is full.
// The row's steering word goes to rsp through the queue write and then the output register,
// which loads a word only when it is empty or its word is being taken.
// Reset (synchronous, active high) clears the row tracker, queue and lost count, sets the
// held speeds to ten and loads the register defaults. Depends on lfs_pkg and submodules.
`timescale 1ns / 1ps

module line_follow_steering_unit import lfs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] pixel_value
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,   // [1:0] direction, [10:2] left_speed,
                                             // [19:11] right_speed, [23:20] zero
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WID_W-1:0]     csr_data
);

   cfg_type                 cfg_ff;
   fifo_status_type         status;
   logic                    pixel_accept;
   logic                    push;
   dir_type                 push_dir;
   logic                    pop;
   dir_type                 pop_dir;
   dir_type                 out_dir;
   logic signed [SPD_W-1:0] out_left;
   logic signed [SPD_W-1:0] out_right;

   assign csr_ready    = 1'b1;
   assign req_tready   = !status.full;
   assign pixel_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width     <= RST_FRAME_WIDTH;
         cfg_ff.white_threshold <= RST_WHITE_THRESHOLD;
         cfg_ff.center_band     <= RST_CENTER_BAND;
         cfg_ff.min_speed       <= RST_MIN_SPEED;
         cfg_ff.max_speed       <= RST_MAX_SPEED;
         cfg_ff.lost_limit      <= RST_LOST_LIMIT;
      end else if (csr_valid) begin
         case (csr_index)
            REG_FRAME_WIDTH:     cfg_ff.frame_width     <= csr_data;
            REG_WHITE_THRESHOLD: cfg_ff.white_threshold <= csr_data[7:0];
            REG_CENTER_BAND:     cfg_ff.center_band     <= csr_data[7:0];
            REG_MIN_SPEED:       cfg_ff.min_speed       <= csr_data[7:0];
            REG_MAX_SPEED:       cfg_ff.max_speed       <= csr_data[7:0];
            REG_LOST_LIMIT:      cfg_ff.lost_limit      <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   lfs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .pixel_accept (pixel_accept),
      .pixel_value  (req_tdata),
      .push         (push),
      .push_dir     (push_dir)
   );

   lfs_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_dir (push_dir),
      .pop      (pop),
      .pop_dir  (pop_dir),
      .status   (status)
   );

   lfs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .status    (status),
      .pop_dir   (pop_dir),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_dir   (out_dir),
      .out_left  (out_left),
      .out_right (out_right)
   );

   assign rsp_tdata = {4'b0000, out_right, out_left, out_dir};

endmodule
